// ===== src/fhtd_pkg.sv =====
// ----------------------------------------------------------------------------
// fhtd_pkg: shared definitions for the frame header tick decoder
// Frame geometry, header layout constants, status codes and the decode
// phase type used by the decoder and the channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package fhtd_pkg;

	// Frame geometry.
	localparam int FRAME_SAMPLES = 256;
	localparam int SAMPLE_W      = 10;
	localparam int IDX_W         = 9;
	localparam int OFFSET_W      = 8;
	localparam int ADDR_W        = 8;

	// The sample index saturates at its largest value.
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	// A tick may only start below this index.
	localparam logic [IDX_W-1:0] TICK_LIMIT = IDX_W'(FRAME_SAMPLES - 12);

	// Header layout relative to the tick start.
	localparam logic [IDX_W-1:0] TICK_END_REL  = IDX_W'(2);
	localparam logic [IDX_W-1:0] ADDR_END_REL  = IDX_W'(10);
	localparam logic [IDX_W-1:0] HEADER_SPAN   = IDX_W'(12);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_TICK   = 2'd1,
		ST_TOO_SHORT = 2'd2
	} status_t;

	// Decode phase within one frame.
	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_TICK   = 2'd1,
		PH_HEADER = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// One sample request as held in the input register.
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} sample_req_t;

endpackage

`default_nettype wire

// ===== src/fhtd_if.sv =====
// ----------------------------------------------------------------------------
// fhtd_if: channel interfaces of the frame header tick decoder
// A sample channel and a result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fhtd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [fhtd_pkg::SAMPLE_W-1:0] sample;
	logic                          last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

interface fhtd_result_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [fhtd_pkg::OFFSET_W-1:0] tick_offset;
	logic [fhtd_pkg::ADDR_W-1:0]   pipeline_address;
	logic                          error_bit;

	modport source (output valid, output status, output tick_offset,
		output pipeline_address, output error_bit, input ready);
	modport sink   (input valid, input status, input tick_offset,
		input pipeline_address, input error_bit, output ready);
endinterface

`default_nettype wire

// ===== src/fhtd_in_stage.sv =====
// ----------------------------------------------------------------------------
// fhtd_in_stage: sample input register
// Registers each accepted sample request and holds it until the decoder
// takes it; a new request is accepted in the same cycle one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fhtd_in_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	fhtd_sample_if.sink                samples,
	input  wire logic                  take,
	output      logic                  valid_s1,
	output      fhtd_pkg::sample_req_t req_s1
);

	// The register is free when empty or being emptied this cycle.
	assign samples.ready = !valid_s1 || take;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	// Payload capture.
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			req_s1.sample <= samples.sample;
			req_s1.last   <= samples.last;
		end
	end

endmodule

`default_nettype wire

// ===== src/fhtd_decode.sv =====
// ----------------------------------------------------------------------------
// fhtd_decode: header decode state and result register
// Tracks the sample index and decode phase of the current frame, gathers
// the tick offset, pipeline address and error bit, and loads the result
// register on the sample marked last.
// ----------------------------------------------------------------------------
`default_nettype none

module fhtd_decode (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [fhtd_pkg::SAMPLE_W-1:0] threshold,
	input  wire logic                          valid_s1,
	input  wire fhtd_pkg::sample_req_t         req_s1,
	output      logic                          take,
	fhtd_result_if.source                      results
);

	fhtd_pkg::phase_t                phase_q, phase_d;
	logic [fhtd_pkg::IDX_W-1:0]      idx_q, idx_d;
	logic [fhtd_pkg::OFFSET_W-1:0]   off_q, off_d;
	logic [fhtd_pkg::ADDR_W-1:0]     addr_q, addr_d;
	logic                            err_q, err_d;
	fhtd_pkg::status_t               stat_q, stat_d;

	logic                            hi;
	logic                            at_or_above;
	logic [fhtd_pkg::IDX_W-1:0]      rel;
	logic                            res_free;
	logic                            done_ok;
	fhtd_pkg::status_t               res_status;

	logic                            res_valid_q;
	fhtd_pkg::status_t               res_status_q;
	logic [fhtd_pkg::OFFSET_W-1:0]   res_off_q;
	logic [fhtd_pkg::ADDR_W-1:0]     res_addr_q;
	logic                            res_err_q;

	// A sample is taken unless it must produce a result and the slot is full.
	assign res_free = !res_valid_q || results.ready;
	assign take     = valid_s1 && (!req_s1.last || res_free);

	// Threshold compares and position relative to the tick start.
	assign hi          = req_s1.sample > threshold;
	assign at_or_above = req_s1.sample >= threshold;
	assign rel         = idx_q - {1'b0, off_q};

	// Phase sequencing and header gathering for the current sample.
	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		addr_d  = addr_q;
		err_d   = err_q;
		stat_d  = stat_q;
		unique case (phase_q)
			fhtd_pkg::PH_SEARCH: begin
				if (idx_q < fhtd_pkg::TICK_LIMIT && at_or_above) begin
					off_d   = idx_q[fhtd_pkg::OFFSET_W-1:0];
					stat_d  = hi ? fhtd_pkg::ST_OK : fhtd_pkg::ST_TOO_SHORT;
					phase_d = fhtd_pkg::PH_TICK;
				end
			end
			fhtd_pkg::PH_TICK: begin
				if (!hi) begin
					stat_d = fhtd_pkg::ST_TOO_SHORT;
				end
				if (rel >= fhtd_pkg::TICK_END_REL) begin
					phase_d = fhtd_pkg::PH_HEADER;
				end
			end
			fhtd_pkg::PH_HEADER: begin
				if (rel <= fhtd_pkg::ADDR_END_REL) begin
					addr_d = {addr_q[fhtd_pkg::ADDR_W-2:0], hi};
				end else begin
					err_d   = hi;
					phase_d = fhtd_pkg::PH_DONE;
				end
			end
			fhtd_pkg::PH_DONE: begin
			end
			default: begin
			end
		endcase

		// Sample index saturates; it restarts with a new frame.
		if (req_s1.last) begin
			idx_d = '0;
		end else if (idx_q < fhtd_pkg::IDX_MAX) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	// Frame verdict: the whole header must lie inside the frame.
	assign done_ok    = (phase_d == fhtd_pkg::PH_DONE) &&
		(idx_q >= ({1'b0, off_d} + fhtd_pkg::HEADER_SPAN));
	assign res_status = done_ok ? stat_d : fhtd_pkg::ST_NO_TICK;

	// Frame state registers; the last sample returns them to a new frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fhtd_pkg::PH_SEARCH;
			idx_q   <= '0;
			off_q   <= '0;
			addr_q  <= '0;
			err_q   <= 1'b0;
			stat_q  <= fhtd_pkg::ST_NO_TICK;
		end else if (take) begin
			idx_q <= idx_d;
			if (req_s1.last) begin
				phase_q <= fhtd_pkg::PH_SEARCH;
				off_q   <= '0;
				addr_q  <= '0;
				err_q   <= 1'b0;
				stat_q  <= fhtd_pkg::ST_NO_TICK;
			end else begin
				phase_q <= phase_d;
				off_q   <= off_d;
				addr_q  <= addr_d;
				err_q   <= err_d;
				stat_q  <= stat_d;
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && req_s1.last) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload; failed frames report zeros in the unused fields.
	always_ff @(posedge clk) begin
		if (take && req_s1.last) begin
			res_status_q <= res_status;
			res_off_q    <= (res_status == fhtd_pkg::ST_NO_TICK) ? '0 : off_d;
			res_addr_q   <= (res_status == fhtd_pkg::ST_OK) ? addr_d : '0;
			res_err_q    <= (res_status == fhtd_pkg::ST_OK) ? err_d : 1'b0;
		end
	end

	assign results.valid            = res_valid_q;
	assign results.status           = res_status_q;
	assign results.tick_offset      = res_off_q;
	assign results.pipeline_address = res_addr_q;
	assign results.error_bit        = res_err_q;

endmodule

`default_nettype wire

// ===== src/frame_header_tick_decoder.sv =====
// ----------------------------------------------------------------------------
// frame_header_tick_decoder: readout frame header decoder
// Finds the tick mark in a stream of frame samples and reports the tick
// offset, pipeline address and error bit once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Samples of a frame enter in order on the samples channel, with last set
//   on the final sample. One request is accepted per cycle while the input
//   register is free. Every sample passes an input register and then
//   updates the decode state; the sample marked last loads the result
//   register, whose outputs drive the results channel. Samples that are
//   not last produce no result. Throughput is one sample per cycle through
//   the single decode stage, unless a last sample waits for the result slot.
//   While a result waits on a stalled receiver, samples that are not last
//   keep flowing; the next last sample waits in the input register until
//   the slot frees.
//   threshold_we writes threshold_wdata into the threshold register; write
//   it only while no frame is in flight. Reset sets the threshold to 512,
//   empties both registers and starts a new frame at sample index zero.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_header_tick_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fhtd_sample_if.sink                        samples,
	fhtd_result_if.source                      results,
	input  wire logic                          threshold_we,
	input  wire logic [fhtd_pkg::SAMPLE_W-1:0] threshold_wdata
);

	logic [fhtd_pkg::SAMPLE_W-1:0] threshold_q;
	logic                          valid_s1;
	fhtd_pkg::sample_req_t         req_s1;
	logic                          take;

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= fhtd_pkg::SAMPLE_W'(512);
		end else if (threshold_we) begin
			threshold_q <= threshold_wdata;
		end
	end

	// Input register.
	fhtd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.take     (take),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	// Decode state and result register.
	fhtd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1),
		.take      (take),
		.results   (results)
	);

endmodule

`default_nettype wire

// ===== src/fhtd_checker.sv =====
// ----------------------------------------------------------------------------
// fhtd_checker: port-level checks for the frame header tick decoder
// Watches the result channel for consistent result contents and a held
// request under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module fhtd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [1:0]                    res_status,
	input wire logic [fhtd_pkg::OFFSET_W-1:0] res_offset,
	input wire logic [fhtd_pkg::ADDR_W-1:0]   res_address,
	input wire logic                          res_error
);

	// A stalled result stays offered.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == fhtd_pkg::ST_OK ||
			res_status == fhtd_pkg::ST_NO_TICK ||
			res_status == fhtd_pkg::ST_TOO_SHORT))
		else $error("undefined result status");

	// A frame without a tick reports no header content.
	a_no_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == fhtd_pkg::ST_NO_TICK |->
			res_offset == '0 && res_address == '0 && !res_error)
		else $error("no-tick result carries header content");

	// A short tick reports an offset but no address or error bit.
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == fhtd_pkg::ST_TOO_SHORT |->
			res_address == '0 && !res_error &&
			{1'b0, res_offset} < fhtd_pkg::TICK_LIMIT)
		else $error("short-tick result inconsistent");

	// A decoded tick always starts inside the allowed window.
	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == fhtd_pkg::ST_OK |->
			{1'b0, res_offset} < fhtd_pkg::TICK_LIMIT)
		else $error("tick offset outside allowed window");

endmodule

bind frame_header_tick_decoder fhtd_checker u_fhtd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_status  (results.status),
	.res_offset  (results.tick_offset),
	.res_address (results.pipeline_address),
	.res_error   (results.error_bit)
);

`default_nettype wire
